>>> rtl/htb_pkg.sv
// htb_pkg: shared types, codes and helper functions of the hex text to bytes block
// no dependencies; imported by the top, front, back and checker modules
`timescale 1ns / 1ps
`default_nettype none

package htb_pkg;

  // kinds of result item
  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_BAD       = 3'd1,
    KIND_STRAY     = 3'd2,
    KIND_DONE_OK   = 3'd3,
    KIND_DONE_FAIL = 3'd4
  } result_kind_e;

  // token classes found by the front end
  typedef enum logic [2:0] {
    TOK_NONE,
    TOK_OPEN,
    TOK_CLOSE,
    TOK_HEX,
    TOK_BAD
  } tok_kind_e;

  // token length saturates at three or more characters
  localparam logic [1:0] TOK_LEN_LONG = 2'd3;

  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;

  localparam logic [15:0] SHOWN_MAX = 16'hffff;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]   byte_value;
    result_kind_e result_kind;
    logic [15:0]  bytes_emitted;
    logic         last_of_run;
  } out_item_t;

  // one closed token (or end marker) handed from front to back
  typedef struct packed {
    tok_kind_e  tok;
    logic [7:0] byte_val;
    logic       is_end;
  } ev_item_t;

  // {valid, nibble} for one ascii hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

`default_nettype wire

>>> rtl/hex_text_to_bytes_top.sv
// hex_text_to_bytes_top: hex dump text to byte stream converter, top level
// depends on htb_pkg, htb_fifo, htb_front, htb_back
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel: a queue write side; one character (or the end marker) is
//   transferred at each rising edge with push high and full low
// - result channel: a queue read side; the oldest result sits on out_data_o
//   while empty is low and is transferred at an edge with pop high
// - throughput: one character per cycle while full is low; the tokenizer takes
//   each character as it comes, and the back end handles one closed token at a
//   time (an end item closing a result token sends that result, then its done)
// - path: the whitespace or end item closing a token enters the token queue at
//   its transfer; the back end writes the result to the queue on out_data_o
// - token queue of 4 entries decouples tokenizer from the state update, and a
//   4-entry result queue parts the back end from the receiver
// - stall: when pop stays low the result queue fills, the back end stops,
//   the token queue fills and full goes high; nothing is dropped
// - reset: all queues empty, level, count and failed state cleared
// - after each end item the block is back in its reset state for a new text

module hex_text_to_bytes_top
  import htb_pkg::*;
#(
  parameter int NEST_WIDTH  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data_i,
  input  wire logic     pop,
  output logic          empty,
  output out_item_t     out_data_o
);

  localparam int EvDepth  = 4;
  localparam int ResDepth = 4;

  logic      accept;
  logic      ev_push, ev_pop, ev_empty;
  ev_item_t  ev_wr, ev_rd;
  logic      res_push, res_full;
  out_item_t res_wr;

  // a transfer is taken whenever the token queue has room
  assign accept = push && !full;

  htb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_data_i),
    .ev_push_o (ev_push),
    .ev_o      (ev_wr)
  );

  // token queue between tokenizer and state update
  htb_fifo #(
    .T     (ev_item_t),
    .DEPTH (EvDepth)
  ) u_ev_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ev_push),
    .wr_data_i (ev_wr),
    .full_o    (full),
    .rd_en_i   (ev_pop),
    .rd_data_o (ev_rd),
    .empty_o   (ev_empty)
  );

  htb_back #(
    .NEST_WIDTH  (NEST_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (!ev_empty),
    .ev_i       (ev_rd),
    .ev_pop_o   (ev_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_wr)
  );

  // result queue; its head drives the result ports directly
  htb_fifo #(
    .T     (out_item_t),
    .DEPTH (ResDepth)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_wr),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (out_data_o),
    .empty_o   (empty)
  );

endmodule

`default_nettype wire

>>> rtl/htb_fifo.sv
// htb_fifo: small register fifo, one write and one read per cycle
// depends on nothing; payload type comes in as a type parameter
`timescale 1ns / 1ps
`default_nettype none

module htb_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_en_i,
  input  wire T     wr_data_i,
  output logic      full_o,
  input  wire logic rd_en_i,
  output T          rd_data_o,
  output logic      empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/htb_front.sv
// htb_front: splits the character stream into tokens and classifies each one
// depends on htb_pkg
`timescale 1ns / 1ps
`default_nettype none

module htb_front
  import htb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output logic          ev_push_o,
  output ev_item_t      ev_o
);

  logic [1:0] tok_len_q, tok_len_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [4:0] hi_dig, lo_dig;
  logic       sp;

  assign hi_dig = hex_digit(first_q);
  assign lo_dig = hex_digit(second_q);
  assign sp     = is_space(item_i.text_char);

  // classify the pending token
  always_comb begin
    ev_o.is_end   = item_i.end_of_text;
    ev_o.byte_val = '0;
    if (tok_len_q == 2'd0) begin
      ev_o.tok = TOK_NONE;
    end else if (tok_len_q == 2'd2 && first_q == CHAR_SLASH && second_q == CHAR_STAR) begin
      ev_o.tok = TOK_OPEN;
    end else if (tok_len_q == 2'd2 && first_q == CHAR_STAR && second_q == CHAR_SLASH) begin
      ev_o.tok = TOK_CLOSE;
    end else if (tok_len_q == 2'd2 && hi_dig[4] && lo_dig[4]) begin
      ev_o.tok      = TOK_HEX;
      ev_o.byte_val = {hi_dig[3:0], lo_dig[3:0]};
    end else begin
      ev_o.tok = TOK_BAD;
    end
  end

  always_comb begin
    tok_len_d = tok_len_q;
    first_d   = first_q;
    second_d  = second_q;
    ev_push_o = 1'b0;
    if (accept_i) begin
      if (item_i.end_of_text) begin
        ev_push_o = 1'b1;
        tok_len_d = '0;
      end else if (sp) begin
        ev_push_o = (tok_len_q != 2'd0);
        tok_len_d = '0;
      end else begin
        if (tok_len_q == 2'd0) begin
          first_d = item_i.text_char;
        end else if (tok_len_q == 2'd1) begin
          second_d = item_i.text_char;
        end
        if (tok_len_q != TOK_LEN_LONG) begin
          tok_len_d = tok_len_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_len_q <= '0;
    end else begin
      tok_len_q <= tok_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

endmodule

`default_nettype wire

>>> rtl/htb_back.sv
// htb_back: applies classified tokens to nesting level, byte count and failed state
// depends on htb_pkg
`timescale 1ns / 1ps
`default_nettype none

module htb_back
  import htb_pkg::*;
#(
  parameter int NEST_WIDTH  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     ev_valid_i,
  input  wire ev_item_t ev_i,
  output logic          ev_pop_o,
  input  wire logic     res_full_i,
  output logic          res_push_o,
  output out_item_t     res_o
);

  localparam logic [NEST_WIDTH-1:0]  NestMax  = {NEST_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [NEST_WIDTH-1:0]  nest_q, nest_d, nest_t;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_t;
  logic                   failed_q, failed_d, failed_t;
  logic                   phase_q, phase_d;  // token result of an end item already sent
  logic                   has_res, fire;
  result_kind_e           tok_kind;
  logic [7:0]             tok_byte;
  logic [31:0]            cnt_wide;
  logic [15:0]            shown;

  assign fire     = ev_valid_i && !res_full_i;
  assign cnt_wide = 32'(cnt_t);
  assign shown    = (cnt_wide > 32'(SHOWN_MAX)) ? SHOWN_MAX : cnt_wide[15:0];

  // effect of the token itself
  always_comb begin
    nest_t   = nest_q;
    cnt_t    = cnt_q;
    failed_t = failed_q;
    has_res  = 1'b0;
    tok_kind = KIND_DATA;
    tok_byte = '0;
    if (!phase_q && !failed_q) begin
      case (ev_i.tok)
        TOK_OPEN: begin
          if (nest_q != NestMax) nest_t = nest_q + 1'b1;
        end
        TOK_CLOSE: begin
          if (nest_q == '0) begin
            failed_t = 1'b1;
            has_res  = 1'b1;
            tok_kind = KIND_STRAY;
          end else begin
            nest_t = nest_q - 1'b1;
          end
        end
        TOK_HEX: begin
          if (nest_q == '0) begin
            has_res  = 1'b1;
            tok_byte = ev_i.byte_val;
            if (cnt_q != CountMax) cnt_t = cnt_q + 1'b1;
          end
        end
        TOK_BAD: begin
          if (nest_q == '0) begin
            failed_t = 1'b1;
            has_res  = 1'b1;
            tok_kind = KIND_BAD;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    nest_d     = nest_q;
    cnt_d      = cnt_q;
    failed_d   = failed_q;
    phase_d    = phase_q;
    ev_pop_o   = 1'b0;
    res_push_o = 1'b0;
    res_o.byte_value    = tok_byte;
    res_o.result_kind   = tok_kind;
    res_o.bytes_emitted = shown;
    res_o.last_of_run   = !ev_i.is_end;
    if (fire) begin
      if (has_res) begin
        res_push_o = 1'b1;
        nest_d     = nest_t;
        cnt_d      = cnt_t;
        failed_d   = failed_t;
        if (ev_i.is_end) phase_d = 1'b1;
        else             ev_pop_o = 1'b1;
      end else if (ev_i.is_end) begin
        res_push_o        = 1'b1;
        res_o.byte_value  = '0;
        res_o.result_kind = failed_t ? KIND_DONE_FAIL : KIND_DONE_OK;
        res_o.last_of_run = 1'b1;
        nest_d   = '0;
        cnt_d    = '0;
        failed_d = 1'b0;
        phase_d  = 1'b0;
        ev_pop_o = 1'b1;
      end else begin
        nest_d   = nest_t;
        ev_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nest_q   <= '0;
      cnt_q    <= '0;
      failed_q <= 1'b0;
      phase_q  <= 1'b0;
    end else begin
      nest_q   <= nest_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
      phase_q  <= phase_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/htb_checker.sv
// htb_checker: port-level assertions for the hex text to bytes block, and its bind
// depends on htb_pkg and hex_text_to_bytes_top
`timescale 1ns / 1ps
`default_nettype none

module htb_checker
  import htb_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      pop,
  input wire logic      empty,
  input wire out_item_t out_data_o
);

  // a waiting result holds until it is transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  // a data byte always counts itself
  a_data_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.result_kind == KIND_DATA) |-> (out_data_o.bytes_emitted != 16'd0))
    else $error("data result with zero count");

  // only data results carry a byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.result_kind != KIND_DATA) |-> (out_data_o.byte_value == 8'd0))
    else $error("non-data result with nonzero byte");

  // a done result closes the run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_data_o.result_kind == KIND_DONE_OK ||
                out_data_o.result_kind == KIND_DONE_FAIL)) |-> out_data_o.last_of_run)
    else $error("done result not last of run");

  // a result that is not last is always followed by the done of its end item
  a_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_data_o.last_of_run) |=>
      (empty || out_data_o.result_kind == KIND_DONE_OK ||
       out_data_o.result_kind == KIND_DONE_FAIL))
    else $error("non-last result not followed by done");

endmodule

bind hex_text_to_bytes_top htb_checker u_htb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .out_data_o (out_data_o)
);

`default_nettype wire
